>>> sv/soqt_pkg.sv
// Shared constants, codes and types of the shape overlap query table.
package soqt_pkg;

  localparam int MAX_SHAPES   = 16;
  localparam int COORD_BITS   = 16;
  localparam int SLOT_W       = $clog2(MAX_SHAPES);
  localparam int SIZE_W       = COORD_BITS - 1;
  localparam int DIFF_W       = COORD_BITS + 1;
  localparam int MAG_W        = COORD_BITS;
  localparam int SQ_W         = 2 * COORD_BITS;

  localparam int MODE_W       = 2;
  localparam int HANDLE_W     = 5;
  localparam int PORT_COORD_W = 16;
  localparam int PORT_SIZE_W  = 15;
  localparam int OUT_HANDLE_W = 4;
  localparam int STATUS_W     = 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_REG   = 2'd0,
    MODE_DEREG = 2'd1,
    MODE_QUERY = 2'd2,
    MODE_NOP   = 2'd3
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK         = 2'd0,
    STS_EMPTY      = 2'd1,
    STS_BAD_HANDLE = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_FLUSH,
    S_EMIT,
    S_RESP
  } state_t;

  typedef struct packed {
    logic                         kind;
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic        [SIZE_W-1:0]     sx;
    logic        [SIZE_W-1:0]     sy;
  } shape_t;

  typedef struct packed {
    logic start;
    logic issue;
    logic load_resp;
    logic load_hit;
  } cmd_t;

  typedef struct packed {
    logic last_idx;
    logic pipe_empty;
    logic hit_last;
  } sts_t;

endpackage

>>> sv/soqt_ram.sv
// Generic single-write, single-read RAM with registered read data.
module soqt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/soqt_ctrl.sv
// Control state machine: accept, slot scan, pipeline flush and result emission.
module soqt_ctrl import soqt_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [MODE_W-1:0] in_mode,
  output logic              in_ready,
  input  logic              out_ready,
  output logic              out_valid,
  output cmd_t              cmd,
  input  sts_t              sts
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = (in_mode == MODE_QUERY) ? S_SCAN : S_RESP;
        end
      end
      S_SCAN: begin
        if (sts.last_idx) begin
          state_nxt = S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (sts.pipe_empty) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free && sts.hit_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_RESP: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready  = 1'b1;
        cmd.start = in_valid;
      end
      S_SCAN:  cmd.issue     = 1'b1;
      S_FLUSH: cmd           = '0;
      S_EMIT:  cmd.load_hit  = out_free;
      S_RESP:  cmd.load_resp = out_free;
      default: cmd           = '0;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_hit || cmd.load_resp) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> sv/soqt_dp.sv
// Datapath: slot table, overlap test pipeline, hit mask and result register.
module soqt_dp import soqt_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  cmd_t                    cmd,
  output sts_t                    sts,
  input  logic [MODE_W-1:0]       in_mode,
  input  logic [HANDLE_W-1:0]     in_handle,
  input  logic                    in_kind,
  input  logic [PORT_COORD_W-1:0] in_pos_x,
  input  logic [PORT_COORD_W-1:0] in_pos_y,
  input  logic [PORT_SIZE_W-1:0]  in_size_x,
  input  logic [PORT_SIZE_W-1:0]  in_size_y,
  output logic                    out_hit_valid,
  output logic [OUT_HANDLE_W-1:0] out_other_handle,
  output logic                    out_last,
  output logic [STATUS_W-1:0]     out_status
);

  // Distance term of one axis (magnitude of the offset); clamp the offset to the box span when asked.
  function automatic logic [MAG_W-1:0] axis_mag(input logic signed [DIFF_W-1:0] d,
                                                input logic [SIZE_W-1:0] w,
                                                input logic clamp);
    logic signed [DIFF_W-1:0] ws;
    logic signed [DIFF_W-1:0] e;
    ws = DIFF_W'(w);
    e  = d;
    if (clamp && d >= 0) begin
      e = (d > ws) ? d - ws : '0;
    end
    return e[DIFF_W-1] ? MAG_W'(-e) : MAG_W'(e);
  endfunction

  // Inclusive interval test of one axis for two boxes.
  function automatic logic axis_touch(input logic signed [DIFF_W-1:0] d,
                                      input logic [SIZE_W-1:0] wb,
                                      input logic [SIZE_W-1:0] wa);
    logic signed [DIFF_W-1:0] wbs;
    logic signed [DIFF_W-1:0] was;
    wbs = DIFF_W'(wb);
    was = DIFF_W'(wa);
    return (d <= wbs) && (d >= -was);
  endfunction

  shape_t                in_shape;
  logic                  handle_ok;
  logic [SLOT_W-1:0]     in_slot;
  logic                  ram_we;
  logic [$bits(shape_t)-1:0] ram_rdata;

  logic [MAX_SHAPES-1:0] valid_r, valid_nxt;
  status_t               resp_sts_r, resp_sts_nxt;
  shape_t                q_r;
  logic [HANDLE_W-1:0]   skip_r;
  logic [SLOT_W-1:0]     idx_r, idx_nxt;
  logic                  live0;

  // stage 0: table read
  logic                  p0_vld_r, p0_live_r;
  logic [SLOT_W-1:0]     p0_slot_r;

  // stage 1: role selection and offsets
  shape_t                a_sh;
  logic                  swap;
  logic signed [COORD_BITS-1:0] px, qx, py, qy;
  logic signed [DIFF_W-1:0] s1_dx_nxt, s1_dy_nxt;
  logic [MAG_W-1:0]      s1_r_nxt;
  logic                  s1_vld_r, s1_live_r, s1_cc_r, s1_bb_r;
  logic [SLOT_W-1:0]     s1_slot_r;
  logic signed [DIFF_W-1:0] s1_dx_r, s1_dy_r;
  logic [SIZE_W-1:0]     s1_wx_r, s1_wy_r, s1_ax_r, s1_ay_r;
  logic [MAG_W-1:0]      s1_r_r;

  // stage 2: distances to nearest point
  logic                  s2_vld_r, s2_live_r, s2_bb_r, s2_bbok_r;
  logic [SLOT_W-1:0]     s2_slot_r;
  logic [MAG_W-1:0]      s2_mx_r, s2_my_r, s2_r_r;

  // stage 3: squares
  logic                  s3_vld_r, s3_live_r, s3_bb_r, s3_bbok_r;
  logic [SLOT_W-1:0]     s3_slot_r;
  logic [SQ_W-1:0]       s3_sqx_r, s3_sqy_r, s3_sqr_r;
  logic                  hit3;

  logic [MAX_SHAPES-1:0] mask_r, mask_nxt;
  logic [SLOT_W-1:0]     first_slot;
  logic                  any_hit;

  logic                  out_hit_r;
  logic [SLOT_W-1:0]     out_slot_r;
  logic                  out_last_r;
  status_t               out_sts_r;

  always_comb begin
    in_shape.kind = in_kind;
    in_shape.x    = in_pos_x[COORD_BITS-1:0];
    in_shape.y    = in_pos_y[COORD_BITS-1:0];
    in_shape.sx   = in_size_x[SIZE_W-1:0];
    in_shape.sy   = in_size_y[SIZE_W-1:0];
  end

  assign handle_ok = int'(in_handle) < MAX_SHAPES;
  assign in_slot   = SLOT_W'(in_handle);

  always_comb begin
    valid_nxt    = valid_r;
    resp_sts_nxt = resp_sts_r;
    ram_we       = 1'b0;
    if (cmd.start) begin
      resp_sts_nxt = STS_OK;
      if (in_mode == MODE_REG || in_mode == MODE_DEREG) begin
        if (!handle_ok) begin
          resp_sts_nxt = STS_BAD_HANDLE;
        end else if (in_mode == MODE_REG) begin
          ram_we             = 1'b1;
          valid_nxt[in_slot] = 1'b1;
        end else if (!valid_r[in_slot]) begin
          resp_sts_nxt = STS_EMPTY;
        end else begin
          valid_nxt[in_slot] = 1'b0;
        end
      end
    end
  end

  soqt_ram #(
    .WIDTH ($bits(shape_t)),
    .DEPTH (MAX_SHAPES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (in_slot),
    .wdata (in_shape),
    .raddr (idx_r),
    .rdata (ram_rdata)
  );

  always_comb begin
    idx_nxt = idx_r;
    if (cmd.start) begin
      idx_nxt = '0;
    end else if (cmd.issue) begin
      idx_nxt = idx_r + SLOT_W'(1);
    end
  end

  assign live0 = valid_r[idx_r] && (HANDLE_W'(idx_r) != skip_r);

  // When the stored shape is a box and the query a circle, swap so the circle sits on the left.
  always_comb begin
    a_sh      = shape_t'(ram_rdata);
    swap      = a_sh.kind && !q_r.kind;
    px        = swap ? q_r.x : a_sh.x;
    qx        = swap ? a_sh.x : q_r.x;
    py        = swap ? q_r.y : a_sh.y;
    qy        = swap ? a_sh.y : q_r.y;
    s1_dx_nxt = DIFF_W'(px) - DIFF_W'(qx);
    s1_dy_nxt = DIFF_W'(py) - DIFF_W'(qy);
    s1_r_nxt  = (a_sh.kind ? '0 : MAG_W'(a_sh.sx)) + (q_r.kind ? '0 : MAG_W'(q_r.sx));
  end

  assign hit3 = s3_live_r &&
                (s3_bb_r ? s3_bbok_r
                         : ((SQ_W+1)'(s3_sqx_r) + (SQ_W+1)'(s3_sqy_r) <=
                            (SQ_W+1)'(s3_sqr_r)));

  always_comb begin
    first_slot = '0;
    for (int i = MAX_SHAPES - 1; i >= 0; i--) begin
      if (mask_r[i]) begin
        first_slot = SLOT_W'(i);
      end
    end
  end

  assign any_hit = |mask_r;

  always_comb begin
    mask_nxt = mask_r;
    if (cmd.start) begin
      mask_nxt = '0;
    end
    if (s3_vld_r && hit3) begin
      mask_nxt[s3_slot_r] = 1'b1;
    end
    if (cmd.load_hit && any_hit) begin
      mask_nxt[first_slot] = 1'b0;
    end
  end

  assign sts.last_idx   = idx_r == SLOT_W'(MAX_SHAPES - 1);
  assign sts.pipe_empty = !(p0_vld_r || s1_vld_r || s2_vld_r || s3_vld_r);
  assign sts.hit_last   = (mask_r & (mask_r - MAX_SHAPES'(1))) == '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      idx_r    <= '0;
      mask_r   <= '0;
      p0_vld_r <= 1'b0;
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else begin
      valid_r  <= valid_nxt;
      idx_r    <= idx_nxt;
      mask_r   <= mask_nxt;
      p0_vld_r <= cmd.issue;
      s1_vld_r <= p0_vld_r;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    resp_sts_r <= resp_sts_nxt;
    if (cmd.start) begin
      q_r    <= in_shape;
      skip_r <= in_handle;
    end

    p0_live_r <= live0;
    p0_slot_r <= idx_r;

    s1_live_r <= p0_live_r;
    s1_slot_r <= p0_slot_r;
    s1_cc_r   <= !a_sh.kind && !q_r.kind;
    s1_bb_r   <= a_sh.kind && q_r.kind;
    s1_dx_r   <= s1_dx_nxt;
    s1_dy_r   <= s1_dy_nxt;
    s1_wx_r   <= swap ? a_sh.sx : q_r.sx;
    s1_wy_r   <= swap ? a_sh.sy : q_r.sy;
    s1_ax_r   <= a_sh.sx;
    s1_ay_r   <= a_sh.sy;
    s1_r_r    <= s1_r_nxt;

    s2_live_r <= s1_live_r;
    s2_slot_r <= s1_slot_r;
    s2_bb_r   <= s1_bb_r;
    s2_bbok_r <= axis_touch(s1_dx_r, s1_wx_r, s1_ax_r) &&
                 axis_touch(s1_dy_r, s1_wy_r, s1_ay_r);
    s2_mx_r   <= axis_mag(s1_dx_r, s1_wx_r, !s1_cc_r);
    s2_my_r   <= axis_mag(s1_dy_r, s1_wy_r, !s1_cc_r);
    s2_r_r    <= s1_r_r;

    s3_live_r <= s2_live_r;
    s3_slot_r <= s2_slot_r;
    s3_bb_r   <= s2_bb_r;
    s3_bbok_r <= s2_bbok_r;
    s3_sqx_r  <= s2_mx_r * s2_mx_r;
    s3_sqy_r  <= s2_my_r * s2_my_r;
    s3_sqr_r  <= s2_r_r * s2_r_r;

    if (cmd.load_resp) begin
      out_hit_r  <= 1'b0;
      out_slot_r <= '0;
      out_last_r <= 1'b1;
      out_sts_r  <= resp_sts_r;
    end else if (cmd.load_hit) begin
      out_hit_r  <= any_hit;
      out_slot_r <= any_hit ? first_slot : '0;
      out_last_r <= sts.hit_last;
      out_sts_r  <= STS_OK;
    end
  end

  assign out_hit_valid    = out_hit_r;
  assign out_other_handle = OUT_HANDLE_W'(out_slot_r);
  assign out_last         = out_last_r;
  assign out_status       = out_sts_r;

endmodule

>>> sv/shape_overlap_query_table.sv
// Top level of the shape overlap query table: controller plus datapath.
// Holds up to 16 circles or axis-aligned boxes, one per slot. Register and
// deregister (and the unused mode) give a single result marked last. A query
// scans the slot table one slot per cycle through the single read port of the
// shape RAM, then lets the overlap pipeline (read, offset, clamp, square,
// compare) drain, then emits one result per hit (a single one when nothing is
// hit), one per cycle while the receiver does not hold them off. One input
// transaction is worked on at a time; the next is accepted once the previous
// result has been loaded into the output register, even while it waits there.
module shape_overlap_query_table import soqt_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [MODE_W-1:0]       in_mode,
  input  logic [HANDLE_W-1:0]     in_handle,
  input  logic                    in_kind,
  input  logic [PORT_COORD_W-1:0] in_pos_x,
  input  logic [PORT_COORD_W-1:0] in_pos_y,
  input  logic [PORT_SIZE_W-1:0]  in_size_x,
  input  logic [PORT_SIZE_W-1:0]  in_size_y,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    out_hit_valid,
  output logic [OUT_HANDLE_W-1:0] out_other_handle,
  output logic                    out_last,
  output logic [STATUS_W-1:0]     out_status
);

  cmd_t cmd;
  sts_t sts;

  soqt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_mode   (in_mode),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .cmd       (cmd),
    .sts       (sts)
  );

  soqt_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_mode          (in_mode),
    .in_handle        (in_handle),
    .in_kind          (in_kind),
    .in_pos_x         (in_pos_x),
    .in_pos_y         (in_pos_y),
    .in_size_x        (in_size_x),
    .in_size_y        (in_size_y),
    .out_hit_valid    (out_hit_valid),
    .out_other_handle (out_other_handle),
    .out_last         (out_last),
    .out_status       (out_status)
  );

endmodule
